[design/vsa_pkg.sv]
// ----------------------------------------------------------------------------
// vsa_pkg: shared types and constants of the VLSM subnet allocator
// Sizes of the request store, field widths, status codes, register indexes
// and the sequencer states.
// ----------------------------------------------------------------------------
package vsa_pkg;

	localparam int MAX_REQUESTS = 64;
	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

	localparam int HOST_W = 32;
	localparam int ADDR_W = 32;
	localparam int PFX_W  = 6;
	localparam int SUM_W  = 38;

	localparam logic [PFX_W-1:0] PFX_LIMIT     = 6'd30;
	localparam logic [PFX_W-1:0] PFX_FULL      = 6'd32;
	localparam logic [PFX_W-1:0] BASE_PFX_RST  = 6'd24;
	localparam int               NORM_STEPS    = 5;

	// Configuration register indexes.
	localparam logic [0:0] REG_BASE_ADDR = 1'b0;
	localparam logic [0:0] REG_BASE_PFX  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_BAD_PREFIX = 2'd1,
		STAT_NO_FIT     = 2'd2,
		STAT_OVERFLOW   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_FETCH,
		S_NORM,
		S_EMIT
	} state_t;

endpackage

[design/vsa_store.sv]
// ----------------------------------------------------------------------------
// vsa_store: request store
// One write port and one registered read port over the stored host counts.
// ----------------------------------------------------------------------------
module vsa_store
	import vsa_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [HOST_W-1:0] wdata,
	input  logic [IDX_W-1:0]  raddr,
	output logic [HOST_W-1:0] rdata
);

	logic [HOST_W-1:0] mem [MAX_REQUESTS];
	logic [HOST_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/vsa_norm.sv]
// ----------------------------------------------------------------------------
// vsa_norm: subnet prefix unit
// Finds the prefix of the smallest block that holds a host count by a
// leading-zero search over hosts + 1, one binary search step per cycle.
// ----------------------------------------------------------------------------
module vsa_norm
	import vsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HOST_W-1:0] hosts,
	output logic              done,
	output logic [PFX_W-1:0]  prefix
);

	logic [HOST_W-1:0] y_q;
	logic [4:0]        lz_q;
	logic [2:0]        step_q;
	logic              run_q;
	logic              done_q;
	logic              zero_q;
	logic              top_q;

	logic [HOST_W:0]   inc;
	logic [4:0]        k;
	logic              hi_zero;
	logic [HOST_W-1:0] y_next;
	logic [4:0]        lz_next;

	always_comb begin
		inc     = {1'b0, hosts} + {{HOST_W{1'b0}}, 1'b1};
		k       = 5'd16 >> step_q;
		hi_zero = (y_q & ~({HOST_W{1'b1}} >> k)) == '0;
		y_next  = hi_zero ? (y_q << k) : y_q;
		lz_next = hi_zero ? (lz_q + k) : lz_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				if (step_q == 3'(NORM_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			y_q    <= inc[HOST_W-1:0];
			top_q  <= inc[HOST_W];
			zero_q <= (hosts == '0);
			lz_q   <= '0;
		end else if (run_q) begin
			y_q  <= y_next;
			lz_q <= lz_next;
		end
	end

	// A zero request and a request that needs the whole address space both
	// map to prefix 0; otherwise the leading-zero count is the prefix, capped.
	always_comb begin
		if (zero_q || top_q) begin
			prefix = '0;
		end else if ({1'b0, lz_q} > PFX_LIMIT) begin
			prefix = PFX_LIMIT;
		end else begin
			prefix = {1'b0, lz_q};
		end
	end

	assign done = done_q;

endmodule

[design/vlsm_subnet_allocator_core.sv]
// ----------------------------------------------------------------------------
// vlsm_subnet_allocator_core: VLSM subnet allocator
// Collects host counts, checks the set against the base network and lays out
// one subnet per request, back to back from the base address.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// request   start / busy         host_count, last_request
// result    result_valid strobe  subnet_address, subnet_prefix, status, last_result
// config    wr_en                wr_index, wr_data
//
// A request that is not the last is written to the store and leaves the block
// idle. The last request adds a check state, then per subnet a store read,
// prefix unit start, five leading-zero search steps plus done, and the address
// add. An error result is registered in the check state. The store needs no
// clearing after reset. Results are shown for one cycle each; the receiver cannot stall.
// ----------------------------------------------------------------------------
module vlsm_subnet_allocator_core
	import vsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [HOST_W-1:0] host_count,
	input  logic              last_request,
	input  logic              wr_en,
	input  logic [0:0]        wr_index,
	input  logic [ADDR_W-1:0] wr_data,
	output logic              result_valid,
	output logic [ADDR_W-1:0] subnet_address,
	output logic [PFX_W-1:0]  subnet_prefix,
	output logic [1:0]        status,
	output logic              last_result
);

	state_t state_q, state_d;

	logic [ADDR_W-1:0] base_addr_q;
	logic [PFX_W-1:0]  base_pfx_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic              ovf_q;
	logic [IDX_W-1:0]  emit_idx_q;
	logic [ADDR_W-1:0] run_addr_q;
	logic [PFX_W-1:0]  prev_pfx_q;

	logic              res_valid_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [PFX_W-1:0]  res_pfx_q;
	status_t           res_status_q;
	logic              res_last_q;

	logic              accept;
	logic              has_room;
	logic [SUM_W:0]    sum_wide;
	logic [SUM_W-1:0]  cap;
	logic              bad_pfx;
	logic              no_fit;
	logic [ADDR_W:0]   blk;
	logic [ADDR_W:0]   next_addr;
	logic [ADDR_W-1:0] emit_addr;
	logic              emit_last;
	logic [HOST_W-1:0] rd_hosts;
	logic              norm_start;
	logic              norm_done;
	logic [PFX_W-1:0]  norm_pfx;

	vsa_store u_store (
		.clk   (clk),
		.we    (accept && has_room),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (host_count),
		.raddr (emit_idx_q),
		.rdata (rd_hosts)
	);

	vsa_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.hosts  (rd_hosts),
		.done   (norm_done),
		.prefix (norm_pfx)
	);

	always_comb begin
		accept     = start && (state_q == S_IDLE);
		has_room   = count_q < CNT_W'(MAX_REQUESTS);
		sum_wide   = {1'b0, sum_q} + (SUM_W + 1)'(host_count);
		cap        = (SUM_W'(1) << (PFX_FULL - base_pfx_q)) - SUM_W'(2);
		bad_pfx    = (base_pfx_q == '0) || (base_pfx_q > PFX_LIMIT);
		no_fit     = (sum_q == '0) || (sum_q > cap);
		blk        = (ADDR_W + 1)'(1) << (PFX_FULL - prev_pfx_q);
		next_addr  = {1'b0, run_addr_q} + blk;
		emit_last  = (CNT_W'(emit_idx_q) + CNT_W'(1)) == count_q;
		norm_start = (state_q == S_FETCH);
		// The first subnet starts at the base; later ones step by the previous
		// block unless the step would run past the top of the address space.
		if (emit_idx_q == '0) begin
			emit_addr = base_addr_q;
		end else if (next_addr[ADDR_W]) begin
			emit_addr = run_addr_q;
		end else begin
			emit_addr = next_addr[ADDR_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && last_request) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (bad_pfx || ovf_q || no_fit) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ:  state_d = S_FETCH;
			S_FETCH: state_d = S_NORM;
			S_NORM: begin
				if (norm_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				state_d = emit_last ? S_IDLE : S_READ;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_addr_q <= '0;
			base_pfx_q  <= BASE_PFX_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_BASE_ADDR: base_addr_q <= wr_data;
				REG_BASE_PFX:  base_pfx_q  <= wr_data[PFX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			emit_idx_q  <= '0;
			run_addr_q  <= '0;
			prev_pfx_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (has_room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						sum_q <= sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
					end
				end
				S_CHECK: begin
					emit_idx_q <= '0;
					if (bad_pfx || ovf_q || no_fit) begin
						res_valid_q <= 1'b1;
						count_q     <= '0;
						sum_q       <= '0;
						ovf_q       <= 1'b0;
					end
				end
				S_EMIT: begin
					res_valid_q <= 1'b1;
					run_addr_q  <= emit_addr;
					prev_pfx_q  <= norm_pfx;
					if (emit_last) begin
						count_q <= '0;
						sum_q   <= '0;
						ovf_q   <= 1'b0;
					end else begin
						emit_idx_q <= emit_idx_q + IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			res_addr_q <= '0;
			res_pfx_q  <= '0;
			res_last_q <= 1'b1;
			if (bad_pfx) begin
				res_status_q <= STAT_BAD_PREFIX;
			end else if (ovf_q) begin
				res_status_q <= STAT_OVERFLOW;
			end else begin
				res_status_q <= STAT_NO_FIT;
			end
		end else if (state_q == S_EMIT) begin
			res_addr_q   <= emit_addr;
			res_pfx_q    <= norm_pfx;
			res_status_q <= STAT_OK;
			res_last_q   <= emit_last;
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign result_valid   = res_valid_q;
	assign subnet_address = res_addr_q;
	assign subnet_prefix  = res_pfx_q;
	assign status         = res_status_q;
	assign last_result    = res_last_q;

	// An error result always closes the run and carries no subnet.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != STAT_OK) |->
			(subnet_address == '0) && (subnet_prefix == '0) && last_result)
		else $error("error result with subnet data or without last mark");

	// The emit walk never reads past the stored requests.
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (CNT_W'(emit_idx_q) < count_q))
		else $error("emit index beyond request count");

	// A completed subnet never has a prefix above that of the smallest block.
	a_pfx_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == STAT_OK) |-> (subnet_prefix <= PFX_LIMIT))
		else $error("subnet prefix out of range");

	// The prefix unit only finishes while the sequencer waits for it.
	a_norm_done: assert property (@(posedge clk) disable iff (!arst_n)
		norm_done |-> (state_q == S_NORM))
		else $error("prefix unit done outside of wait state");

	// The last result of a run leaves the block ready for the next run.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_result |-> !busy)
		else $error("block still busy after the last result");

endmodule
